// ----- design/tbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types and constants for the tone bit detector.
// ----------------------------------------------------------------------------
package tbd_pkg;

    localparam int LEVEL_W  = 10;
    localparam int INDEX_W  = 4;
    localparam int TIMING_W = 8;
    localparam int OUT_W    = 8;
    localparam int POS_W    = 3;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Input operation codes (op field on s_tuser).
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_POLL    = 2'd1;
    localparam logic [1:0] PH_SETTLE  = 2'd2;
    localparam logic [1:0] PH_CONFIRM = 2'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_BIT_LENGTH    = 3'd1;
    localparam logic [2:0] REG_POLL_INTERVAL = 3'd2;
    localparam logic [2:0] REG_POLL_COUNT    = 3'd3;
    localparam logic [2:0] REG_SETTLE_TIME   = 3'd4;

    localparam logic [LEVEL_W-1:0]  RST_THRESHOLD     = 10'd512;
    localparam logic [INDEX_W-1:0]  RST_BIT_LENGTH    = 4'd8;
    localparam logic [TIMING_W-1:0] RST_POLL_INTERVAL = 8'd5;
    localparam logic [TIMING_W-1:0] RST_POLL_COUNT    = 8'd40;
    localparam logic [TIMING_W-1:0] RST_SETTLE_TIME   = 8'd30;

    typedef struct packed {
        logic [LEVEL_W-1:0]  threshold;
        logic [INDEX_W-1:0]  bit_length;
        logic [TIMING_W-1:0] poll_interval;
        logic [TIMING_W-1:0] poll_count;
        logic [TIMING_W-1:0] settle_time;
    } tbd_cfg_t;

    typedef struct packed {
        logic             tone_now;
        logic [OUT_W-1:0] assembled_value;
        logic             bit_value;
        logic             ok;
        logic             done_res;
        logic             busy_res;
    } tbd_result_t;

    // A timing register of zero behaves as one.
    function automatic logic [TIMING_W-1:0] at_least_one(input logic [TIMING_W-1:0] v);
        return (v == '0) ? TIMING_W'(1) : v;
    endfunction

endpackage

// ----- design/tbd_cfg.sv -----
// ----------------------------------------------------------------------------
// tbd_cfg
// APB register bank holding the detector's timing and threshold settings.
// ----------------------------------------------------------------------------
module tbd_cfg
    import tbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output tbd_cfg_t              cfg
);

    tbd_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold     <= RST_THRESHOLD;
            cfg_reg.bit_length    <= RST_BIT_LENGTH;
            cfg_reg.poll_interval <= RST_POLL_INTERVAL;
            cfg_reg.poll_count    <= RST_POLL_COUNT;
            cfg_reg.settle_time   <= RST_SETTLE_TIME;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_THRESHOLD:     cfg_reg.threshold     <= pwdata[LEVEL_W-1:0];
                REG_BIT_LENGTH:    cfg_reg.bit_length    <= pwdata[INDEX_W-1:0];
                REG_POLL_INTERVAL: cfg_reg.poll_interval <= pwdata[TIMING_W-1:0];
                REG_POLL_COUNT:    cfg_reg.poll_count    <= pwdata[TIMING_W-1:0];
                REG_SETTLE_TIME:   cfg_reg.settle_time   <= pwdata[TIMING_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_THRESHOLD:     prdata = CFG_DATA_W'(cfg_reg.threshold);
            REG_BIT_LENGTH:    prdata = CFG_DATA_W'(cfg_reg.bit_length);
            REG_POLL_INTERVAL: prdata = CFG_DATA_W'(cfg_reg.poll_interval);
            REG_POLL_COUNT:    prdata = CFG_DATA_W'(cfg_reg.poll_count);
            REG_SETTLE_TIME:   prdata = CFG_DATA_W'(cfg_reg.settle_time);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- design/tbd_core.sv -----
// ----------------------------------------------------------------------------
// tbd_core
// Poll, settle and confirm sequencer with the stored bit register.
// ----------------------------------------------------------------------------
module tbd_core
    import tbd_pkg::*;
#(
    parameter int BIT_SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [1:0]         op,
    input  logic [INDEX_W-1:0] bit_index,
    input  logic [LEVEL_W-1:0] level,
    input  tbd_cfg_t           cfg,
    output tbd_result_t        res,
    output logic [1:0]         phase
);

    localparam logic [INDEX_W-1:0] SLOTS_LIMIT = INDEX_W'(BIT_SLOTS);

    logic [BIT_SLOTS-1:0] bits_reg,    bits_next;
    logic [1:0]           phase_reg,   phase_next;
    logic [TIMING_W-1:0]  tick_reg,    tick_next;
    logic [TIMING_W-1:0]  polls_reg,   polls_next;
    logic [POS_W-1:0]     target_reg,  target_next;
    logic                 confirm_reg, confirm_next;

    logic                 tone;
    logic                 do_poll;
    logic [TIMING_W-1:0]  poll_cnt;
    logic [TIMING_W-1:0]  tick_dec;
    logic [INDEX_W-1:0]   limit;
    logic [BIT_SLOTS-1:0] pos_mask;
    logic                 done, ok, bitv;

    assign tone     = level > cfg.threshold;
    assign tick_dec = tick_reg - TIMING_W'(1);
    assign limit    = (cfg.bit_length == '0 || cfg.bit_length > SLOTS_LIMIT)
                      ? SLOTS_LIMIT : cfg.bit_length;

    always_comb begin
        for (int i = 0; i < BIT_SLOTS; i++) begin
            pos_mask[i] = (target_reg == POS_W'(i));
        end
    end

    always_comb begin
        bits_next    = bits_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        polls_next   = polls_reg;
        target_next  = target_reg;
        confirm_next = confirm_reg;
        do_poll      = 1'b0;
        poll_cnt     = polls_reg + TIMING_W'(1);
        done         = 1'b0;
        ok           = 1'b0;
        bitv         = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (op == OP_START) begin
                    if (bit_index == '0 || bit_index > limit) begin
                        done = 1'b1;
                    end else begin
                        target_next  = POS_W'(bit_index - INDEX_W'(1));
                        confirm_next = 1'b0;
                        poll_cnt     = TIMING_W'(1);
                        do_poll      = 1'b1;
                    end
                end else if (op == OP_CLEAR) begin
                    bits_next = '0;
                end
            end
            PH_POLL: begin
                tick_next = tick_dec;
                if (tick_dec == '0) begin
                    do_poll = 1'b1;
                end
            end
            PH_SETTLE: begin
                tick_next = tick_dec;
                if (tick_dec == '0) begin
                    confirm_next = tone;
                    phase_next   = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                bitv       = confirm_reg || tone;
                bits_next  = bitv ? (bits_reg | pos_mask) : (bits_reg & ~pos_mask);
                phase_next = PH_IDLE;
                tick_next  = '0;
                done       = 1'b1;
                ok         = 1'b1;
            end
            default: ;
        endcase

        if (do_poll) begin
            polls_next = poll_cnt;
            if (tone) begin
                phase_next = PH_SETTLE;
                tick_next  = at_least_one(cfg.settle_time);
            end else if (poll_cnt >= at_least_one(cfg.poll_count)) begin
                phase_next = PH_IDLE;
                tick_next  = '0;
                done       = 1'b1;
            end else begin
                phase_next = PH_POLL;
                tick_next  = at_least_one(cfg.poll_interval);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg    <= '0;
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            polls_reg   <= '0;
            target_reg  <= '0;
            confirm_reg <= 1'b0;
        end else if (step_en) begin
            bits_reg    <= bits_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            polls_reg   <= polls_next;
            target_reg  <= target_next;
            confirm_reg <= confirm_next;
        end
    end

    assign res.busy_res        = (phase_next != PH_IDLE);
    assign res.done_res        = done;
    assign res.ok              = ok;
    assign res.bit_value       = bitv;
    assign res.assembled_value = OUT_W'(bits_next);
    assign res.tone_now        = tone;
    assign phase               = phase_reg;

endmodule

// ----- design/tone_bit_detector.sv -----
// ----------------------------------------------------------------------------
// tone_bit_detector
// Reads on-off keyed tone bits from a per-tick tone level stream.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   one tick: op, bit index, level
//  m_*       out        m_tvalid/m_tready   one result per tick: status + bits
//  APB       in         psel/penable        five setting registers
//
// Each tick transaction is captured in an input register, evaluated by the
// sequencer combinationally and written to the result register, one
// transaction per cycle while m_tready does not stall. The sequencer state
// advances only when a transaction moves from the input register into the
// result register. A stall on m_tready holds the result register and then
// the input register; the slave side stays ready while the result register
// is being drained. Reset is synchronous and active low; the settings
// return to their documented defaults.
//
module tone_bit_detector
    import tbd_pkg::*;
#(
    parameter int BIT_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Tick stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // [3:0] bit_index, [13:4] level, [15:14] zero
    input  logic [1:0]            s_tuser,  // [1:0] op
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,  // [0] busy_res, [1] done_res, [2] ok,
                                            // [3] bit_value, [11:4] assembled_value,
                                            // [12] tone_now, [15:13] zero
    // Settings port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    tbd_cfg_t    cfg;
    tbd_result_t core_res;
    logic [1:0]  core_phase;

    // Input register stage.
    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [INDEX_W-1:0] in_index_reg;
    logic [LEVEL_W-1:0] in_level_reg;

    // Result register stage.
    logic        out_valid_reg;
    tbd_result_t out_res_reg;

    logic advance;
    logic s_take;

    // A transaction moves forward when the result register is empty or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    tbd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbd_core #(
        .BIT_SLOTS (BIT_SLOTS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .op        (in_op_reg),
        .bit_index (in_index_reg),
        .level     (in_level_reg),
        .cfg       (cfg),
        .res       (core_res),
        .phase     (core_phase)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // The payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_op_reg    <= s_tuser;
            in_index_reg <= s_tdata[3:0];
            in_level_reg <= s_tdata[13:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.tone_now,
                       out_res_reg.assembled_value,
                       out_res_reg.bit_value,
                       out_res_reg.ok,
                       out_res_reg.done_res,
                       out_res_reg.busy_res};

    // A finished sequence never reports itself as still running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.done_res) |-> !out_res_reg.busy_res)
        else $error("done result reported busy");

    // A stored bit or a decided bit only comes with the end of a sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res_reg.ok || out_res_reg.bit_value)) |-> out_res_reg.done_res)
        else $error("ok or bit_value without done");

    // The busy flag of the latest result matches the sequencer phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ((core_phase != PH_IDLE) == out_res_reg.busy_res))
        else $error("busy flag disagrees with sequencer phase");

    // The sequencer never moves without a transaction passing through.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(core_phase))
        else $error("sequencer phase changed without a transaction");

endmodule

// ----- sim/tone_bit_detector_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_bit_detector_checker
// Predicts and checks every result transaction of the tone bit detector.
// ----------------------------------------------------------------------------
// Watches the settings port, the tick stream and the result stream. Every
// accepted tick runs through a behavioral copy of the bit reader, and the
// expected result is queued. Every accepted result is compared, field by
// field, with the oldest queued entry.
// ----------------------------------------------------------------------------
module tone_bit_detector_checker
    import tbd_pkg::*;
#(
    parameter int BIT_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatch_count,
    output int                    results_pending,
    output logic                  sequence_running
);

    tbd_cfg_t          settings;
    logic [OUT_W-1:0]  stored_bits;
    logic [1:0]        seq_phase;
    logic [7:0]        countdown;
    logic [7:0]        polls_taken;
    logic [POS_W-1:0]  slot;
    logic              early_hit;
    tbd_result_t       expected_results[$];
    int                errors = 0;
    int                results_seen = 0;

    function automatic logic [TIMING_W-1:0] floor_one(input logic [TIMING_W-1:0] v);
        return (v == '0) ? TIMING_W'(1) : v;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    // One poll of the tone level. A hit moves on to the settle wait; a miss
    // either schedules the next poll or gives up once the budget is spent.
    task automatic take_poll(input logic tone, output logic gave_up);
        polls_taken = polls_taken + 8'd1;
        gave_up     = 1'b0;
        if (tone) begin
            seq_phase = PH_SETTLE;
            countdown = floor_one(settings.settle_time);
        end else if (polls_taken >= floor_one(settings.poll_count)) begin
            seq_phase = PH_IDLE;
            countdown = '0;
            gave_up   = 1'b1;
        end else begin
            seq_phase = PH_POLL;
            countdown = floor_one(settings.poll_interval);
        end
    endtask

    task automatic predict_tick(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [LEVEL_W-1:0] lvl, output tbd_result_t r);
        logic tone;
        logic gave_up;
        int   cap;
        r    = '0;
        tone = (lvl > settings.threshold);
        case (seq_phase)
            PH_IDLE: begin
                if (op == OP_START) begin
                    cap = settings.bit_length;
                    if (cap == 0 || cap > BIT_SLOTS) cap = BIT_SLOTS;
                    if (idx < 1 || idx > cap) begin
                        r.done_res = 1'b1;
                    end else begin
                        slot        = POS_W'(idx - 1);
                        polls_taken = '0;
                        early_hit   = 1'b0;
                        take_poll(tone, gave_up);
                        r.done_res  = gave_up;
                    end
                end else if (op == OP_CLEAR) begin
                    stored_bits = '0;
                end
            end
            PH_POLL: begin
                countdown = countdown - 8'd1;
                if (countdown == '0) begin
                    take_poll(tone, gave_up);
                    r.done_res = gave_up;
                end
            end
            PH_SETTLE: begin
                countdown = countdown - 8'd1;
                if (countdown == '0) begin
                    early_hit = tone;
                    seq_phase = PH_CONFIRM;
                end
            end
            default: begin
                r.bit_value       = early_hit | tone;
                stored_bits[slot] = r.bit_value;
                seq_phase         = PH_IDLE;
                countdown         = '0;
                r.done_res        = 1'b1;
                r.ok              = 1'b1;
            end
        endcase
        r.busy_res        = (seq_phase != PH_IDLE);
        r.assembled_value = stored_bits;
        r.tone_now        = tone;
    endtask

    always @(posedge aclk) begin : monitor
        tbd_result_t want;
        tbd_result_t got;
        if (!aresetn) begin
            settings.threshold     = RST_THRESHOLD;
            settings.bit_length    = RST_BIT_LENGTH;
            settings.poll_interval = RST_POLL_INTERVAL;
            settings.poll_count    = RST_POLL_COUNT;
            settings.settle_time   = RST_SETTLE_TIME;
            stored_bits = '0;
            seq_phase   = PH_IDLE;
            countdown   = '0;
            polls_taken = '0;
            slot        = '0;
            early_hit   = 1'b0;
            expected_results.delete();
        end else begin
            // Results leave before this edge's tick enters, so a result can
            // never be matched against the transaction accepted beside it.
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = m_tdata[$bits(tbd_result_t)-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_results.pop_front();
                    check_field("busy_res", got.busy_res, want.busy_res);
                    check_field("done_res", got.done_res, want.done_res);
                    check_field("ok", got.ok, want.ok);
                    check_field("bit_value", got.bit_value, want.bit_value);
                    check_field("assembled_value", got.assembled_value, want.assembled_value);
                    check_field("tone_now", got.tone_now, want.tone_now);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_THRESHOLD:     settings.threshold     = pwdata[LEVEL_W-1:0];
                    REG_BIT_LENGTH:    settings.bit_length    = pwdata[INDEX_W-1:0];
                    REG_POLL_INTERVAL: settings.poll_interval = pwdata[TIMING_W-1:0];
                    REG_POLL_COUNT:    settings.poll_count    = pwdata[TIMING_W-1:0];
                    REG_SETTLE_TIME:   settings.settle_time   = pwdata[TIMING_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tuser, s_tdata[INDEX_W-1:0],
                             s_tdata[INDEX_W +: LEVEL_W], want);
                expected_results.push_back(want);
            end
        end
        mismatch_count   <= errors;
        results_pending  <= expected_results.size();
        sequence_running <= (seq_phase != PH_IDLE);
    end

endmodule

// ----- sim/tone_bit_detector_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_bit_detector_tb
// Stimulus and verdict for the tone bit detector.
// ----------------------------------------------------------------------------
// A short directed run walks through bad indexes, the plain and unused
// operations, hits on either confirm sample, a timeout, ignored requests
// while busy and clearing. Random phases follow, each under its own settings,
// reaching the register extremes (zero timing values, limits of 0 and above
// eight, threshold 0 and 1023, the longest waits). The checker beside the
// block predicts and compares every result; this module drives and judges.
// ----------------------------------------------------------------------------
module tone_bit_detector_tb;
    import tbd_pkg::*;

    localparam int         SLOTS       = 8;
    // Cycles without any stream transaction before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off plus a few
    // settings writes, well below this.
    localparam int         QUIET_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 60;
    // The op code that the block treats as a plain tick.
    localparam logic [1:0] OP_SPARE    = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // [3:0] bit_index, [13:4] level, [15:14] zero
    logic [1:0]            s_tuser;   // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // [0] busy_res, [1] done_res, [2] ok, [3] bit_value,
                                      // [11:4] assembled_value, [12] tone_now, [15:13] zero
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int   mismatch_count;
    int   results_pending;
    logic sequence_running;

    // Idle rates in percent for the sender and the receiver.
    int   send_gap_pct  = 7;
    int   recv_gap_pct  = 53;
    // A request for a long receiver hold-off is raised by bumping this count.
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   quiet_cycles  = 0;

    tone_bit_detector #(
        .BIT_SLOTS (SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tone_bit_detector_checker #(
        .BIT_SLOTS (SLOTS)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatch_count   (mismatch_count),
        .results_pending  (results_pending),
        .sequence_running (sequence_running)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver. Each cycle it decides at random whether to take a result.
    // When a hold-off is requested it refuses results for a long stretch,
    // so that the block fills up and has to stall the tick stream.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = holds_served + 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Watchdog. Any transaction on either stream restarts the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // A settings write: setup cycle, then access cycle; the register takes
    // the value at the edge where the access phase meets pready.
    task automatic write_setting(input logic [2:0] index, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one tick transaction, after an optional random gap, and returns
    // at the edge where it is accepted. tvalid stays high for a following
    // transaction unless that one starts with a gap.
    task automatic offer_tick(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic [LEVEL_W-1:0] lvl);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, lvl, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every expected result has come out.
    // The first edge lets the checker's counters catch up with the last
    // accepted tick.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Lets any running bit read finish with plain ticks, then rewrites all
    // five registers while the block is idle.
    task automatic load_settings(input logic [LEVEL_W-1:0] thr, input logic [INDEX_W-1:0] blen,
                                 input logic [7:0] pint, input logic [7:0] pcnt,
                                 input logic [7:0] stime);
        wait_for_results();
        while (sequence_running) begin
            offer_tick(OP_TICK, INDEX_W'($urandom_range(0, 15)), LEVEL_W'($urandom));
            wait_for_results();
        end
        write_setting(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_setting(REG_BIT_LENGTH, CFG_DATA_W'(blen));
        write_setting(REG_POLL_INTERVAL, CFG_DATA_W'(pint));
        write_setting(REG_POLL_COUNT, CFG_DATA_W'(pcnt));
        write_setting(REG_SETTLE_TIME, CFG_DATA_W'(stime));
    endtask

    // Levels are spread so that tone and silence are about equally likely,
    // with the edges around the threshold picked often.
    function automatic logic [LEVEL_W-1:0] pick_level(input logic [LEVEL_W-1:0] thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && thr != 10'h3FF) return LEVEL_W'($urandom_range(int'(thr) + 1, 1023));
        if (r < 80) return LEVEL_W'($urandom_range(0, int'(thr)));
        case ($urandom_range(0, 3))
            0: return 10'd0;
            1: return 10'h3FF;
            2: return thr;
            default: return (thr == 10'h3FF) ? thr : thr + 10'd1;
        endcase
    endfunction

    // One random phase under fixed settings. Most starts carry an index the
    // settings accept, so most starts taken while the block is idle begin a poll
    // sequence; the rest hit the bad-index path.
    task automatic run_phase(input logic [LEVEL_W-1:0] thr, input logic [INDEX_W-1:0] blen,
                             input logic [7:0] pint, input logic [7:0] pcnt,
                             input logic [7:0] stime, input int count,
                             input int s_pct, input int r_pct, input logic squeeze);
        int         lim;
        int         r;
        logic [1:0] op;
        lim = (blen == 0 || blen > SLOTS) ? SLOTS : blen;
        load_settings(thr, blen, pint, pcnt, stime);
        send_gap_pct = s_pct;
        recv_gap_pct <= r_pct;
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == count / 2) hold_requests <= hold_requests + 1;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                op = OP_START;
            end else if (r < 80) begin
                op = OP_TICK;
            end else if (r < 90) begin
                op = OP_CLEAR;
            end else begin
                op = OP_SPARE;
            end
            offer_tick(op,
                       ($urandom_range(0, 4) == 0) ? INDEX_W'($urandom_range(0, 15))
                                                   : INDEX_W'($urandom_range(1, lim)),
                       pick_level(thr));
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Short timing: two polls two ticks apart, and the
        // first confirm sample one tick after a hit.
        load_settings(10'd512, 4'd8, 8'd2, 8'd2, 8'd1);
        offer_tick(OP_CLEAR, 4'd0, 10'd0);
        // Bad indexes end at once: zero, just above the limit, the largest.
        offer_tick(OP_START, 4'd0, 10'h3FF);
        offer_tick(OP_START, 4'd9, 10'd0);
        offer_tick(OP_START, 4'd15, 10'h3FF);
        // The unused op code is only a tick.
        offer_tick(OP_SPARE, 4'd8, 10'h3FF);
        // Hit on the start tick; only the second confirm sample sees tone.
        offer_tick(OP_START, 4'd8, 10'h3FF);
        offer_tick(OP_TICK, 4'd0, 10'd0);
        offer_tick(OP_TICK, 4'd0, 10'd513);
        // A level equal to the threshold is silence. Both polls miss; the
        // start in between is ignored because the block is busy.
        offer_tick(OP_START, 4'd1, 10'd512);
        offer_tick(OP_START, 4'd3, 10'h3FF);
        offer_tick(OP_TICK, 4'd0, 10'd100);
        // Only the first confirm sample sees tone.
        offer_tick(OP_START, 4'd1, 10'd600);
        offer_tick(OP_TICK, 4'd0, 10'd700);
        offer_tick(OP_TICK, 4'd0, 10'd0);
        // Miss, then a hit on the second poll, then silence: a zero is
        // stored, and the clear on the last tick is ignored.
        offer_tick(OP_START, 4'd2, 10'd0);
        offer_tick(OP_TICK, 4'd0, 10'h3FF);
        offer_tick(OP_TICK, 4'd0, 10'd900);
        offer_tick(OP_TICK, 4'd0, 10'd0);
        offer_tick(OP_CLEAR, 4'd0, 10'd0);
        // Clear while idle wipes every stored bit.
        offer_tick(OP_CLEAR, 4'd0, 10'h3FF);
        // A clear during a read does not touch the bit being read.
        offer_tick(OP_START, 4'd4, 10'h3FF);
        offer_tick(OP_CLEAR, 4'd0, 10'h3FF);
        offer_tick(OP_TICK, 4'd0, 10'd0);

        // Random phases. Sender idles rarely and receiver often first, then
        // the other way round, then neither idles.
        run_phase(LEVEL_W'($urandom_range(1, 1022)), 4'd0, 8'd1, 8'd3, 8'd2, 140,
                  7, 53, 1'b0);
        // Never any tone: every read runs the full 255 polls and times out.
        run_phase(10'h3FF, 4'd15, 8'd1, 8'd255, 8'd0, 130, 7, 53, 1'b0);
        // Zero timing values act as one: a first miss is already a timeout.
        run_phase(LEVEL_W'($urandom_range(1, 1022)), 4'd1, 8'd0, 8'd0, 8'd0, 120,
                  53, 7, 1'b0);
        // The longest poll gap and settle wait.
        run_phase(10'd600, 4'd4, 8'd255, 8'd2, 8'd255, 120, 53, 7, 1'b0);
        // Threshold zero: any nonzero level is tone.
        run_phase(10'd0, 4'd8, 8'd3, 8'd5, 8'd1, 120, 0, 0, 1'b0);
        run_phase(LEVEL_W'($urandom_range(1, 1022)), 4'd7, 8'd2, 8'd4, 8'd2, 110,
                  0, 0, 1'b1);
        run_phase(LEVEL_W'($urandom_range(1, 1022)), INDEX_W'($urandom_range(0, 15)),
                  8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  8'($urandom_range(1, 6)), 110, 0, 0, 1'b0);

        // Drain, then allow for the block's latency and some margin
        // for any stray result before the verdict.
        wait_for_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
